// ----- rtl/bitmap_id_allocator_defines.svh -----
// Assertion macros for the bitmap identifier allocator.
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BIA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BIA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BIA_ASSERT(lbl, clk, rst, prop, msg)
`define BIA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/bia_pkg.sv -----
// Shared constants, types and helpers of the bitmap identifier allocator.
`default_nettype none
package bia_pkg;
  // Supported: 64 <= ID_COUNT <= 32768 (at most 32 summary groups).
  localparam int ID_COUNT  = 32768;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int ID_W      = 15;
  localparam int WORDS     = ID_COUNT / WORD_W;
  localparam int WADDR     = $clog2(WORDS);
  localparam int GROUPS    = (WORDS + WORD_W - 1) / WORD_W;
  localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WIDX_W    = GRP_W + BIT_W;
  localparam int IDX_W     = WIDX_W + BIT_W;
  localparam int ID_LIMIT  = WORDS * WORD_W;
  localparam int RESERVED_IDS = 2;

  localparam logic [WORD_W-1:0] FULL_WORD     = 32'hffff_ffff;
  localparam logic [WORD_W-1:0] RESERVED_MASK = 32'd3;
  // groups beyond the last real one read as full
  localparam logic [WORD_W-1:0] TOP_RESET =
    WORD_W'(~((64'd1 << GROUPS) - 64'd1));

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_WORD,
    S_REL
  } state_t;

  // Initial summary word of a group: words past the end are marked full.
  function automatic logic [WORD_W-1:0] sum_init(input logic [GRP_W-1:0] g);
    logic [WORD_W-1:0] v;
    v = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (int'(g) * WORD_W + k >= WORDS) v[k] = 1'b1;
    end
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/bia_cmd_if.sv -----
// Command channel: allocate or release transactions.
`default_nettype none
interface bia_cmd_if;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [bia_pkg::ID_W-1:0] release_id;

  modport source (output valid, output command, output release_id, input ready);
  modport sink   (input valid, input command, input release_id, output ready);
endinterface
`default_nettype wire

// ----- rtl/bia_res_if.sv -----
// Result channel: granted identifier transactions.
`default_nettype none
interface bia_res_if;
  logic                   valid;
  logic                   ready;
  logic [bia_pkg::ID_W-1:0] granted_id;

  modport source (output valid, output granted_id, input ready);
  modport sink   (input valid, input granted_id, output ready);
endinterface
`default_nettype wire

// ----- rtl/bitmap_id_allocator.sv -----
// Top level of the bitmap identifier allocator: sequencer, bitmap and summary.
// Usage:
//   cmd (sink): command 0 allocates the lowest free identifier, command 1
//   releases release_id. Releases of 0, 1 or of ids past the bitmap are
//   accepted and dropped. res (source): one granted_id per allocate, 0 when
//   every identifier is taken. Releases give no result transaction.
// Timing:
//   An allocate walks three levels with one shared lowest-zero encoder: the
//   group vector register, a summary word (one full flag per bitmap word),
//   then the bitmap word. The last two wait on registered memory reads (in
//   S_SUM, then S_WORD); res.valid rises as the sequencer returns to S_IDLE,
//   where the next command can be taken. A full bitmap raises res.valid in
//   the cycle after acceptance. A release reads its words, then writes back.
// Reset:
//   rst is synchronous. After it, a clearing pass writes the 1024 bitmap
//   words (and the summary words), one per cycle, so cmd.ready stays low
//   until the pass ends. Word 0 comes up as 3: identifiers 0 and 1 are reserved.
// Stall:
//   The result sits in an output register. While it waits no command is
//   taken; cmd.ready returns in the cycle res.ready is high.
`default_nettype none
`include "bitmap_id_allocator_defines.svh"
module bitmap_id_allocator (
  input  logic      clk,
  input  logic      rst,
  bia_cmd_if.sink   cmd,
  bia_res_if.source res
);
  localparam int WW = bia_pkg::WORD_W;

  bia_pkg::state_t state, state_next;

  // memories
  logic [WW-1:0] bm_mem  [bia_pkg::WORDS];
  logic [WW-1:0] sum_mem [bia_pkg::GROUPS];
  logic [WW-1:0] bm_q, sum_q;
  logic                        bm_we, sum_we;
  logic [bia_pkg::WADDR-1:0]   bm_waddr, bm_raddr;
  logic [bia_pkg::GRP_W-1:0]   sum_waddr, sum_raddr;
  logic [WW-1:0]               bm_wdata, sum_wdata;

  // sequencer registers
  logic [bia_pkg::WADDR:0]     clr_cnt;
  logic [WW-1:0]               top;
  logic                        top_set, top_clr;
  logic [bia_pkg::GRP_W-1:0]   grp;
  logic [bia_pkg::BIT_W-1:0]   wsel, rbit;
  logic                        res_valid;
  logic [bia_pkg::ID_W-1:0]    gid;
  logic                        gid_load;
  logic [bia_pkg::ID_W-1:0]    gid_next;

  // shared encoder
  logic [WW-1:0]               ffz_in;
  logic [bia_pkg::BIT_W-1:0]   ffz_idx;
  logic                        ffz_full;

  logic                        in_ready, acc;
  logic                        rel_ok;
  logic [bia_pkg::IDX_W-1:0]   id_ext;
  logic [bia_pkg::WIDX_W-1:0]  rel_widx, srch_widx, cur_widx;
  logic [bia_pkg::GRP_W-1:0]   rel_grp;
  logic [WW-1:0]               bm_set, sum_set;
  logic [31:0]                 gid_wide;

  bia_ffz u_ffz (
    .word (ffz_in),
    .idx  (ffz_idx),
    .full (ffz_full)
  );

  assign in_ready  = (state == bia_pkg::S_IDLE) && (!res_valid || res.ready);
  assign acc       = cmd.valid && in_ready;
  assign cmd.ready = in_ready;
  assign res.valid = res_valid;
  assign res.granted_id = gid;

  // release decode
  assign id_ext   = bia_pkg::IDX_W'(cmd.release_id);
  assign rel_widx = id_ext[bia_pkg::IDX_W-1:bia_pkg::BIT_W];
  assign rel_grp  = id_ext[bia_pkg::IDX_W-1:bia_pkg::WIDX_W];
  assign rel_ok   = (32'(cmd.release_id) >= 32'(bia_pkg::RESERVED_IDS)) &&
                    (32'(cmd.release_id) < 32'(bia_pkg::ID_LIMIT));

  assign srch_widx = {grp, ffz_idx};
  assign cur_widx  = {grp, wsel};
  assign bm_set    = bm_q | (WW'(1) << ffz_idx);
  assign sum_set   = sum_q | (WW'(1) << wsel);
  assign gid_wide  = 32'({cur_widx, ffz_idx});

  always_comb begin
    case (state)
      bia_pkg::S_IDLE: ffz_in = top;
      bia_pkg::S_SUM:  ffz_in = sum_q;
      default:         ffz_in = bm_q;
    endcase
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    bm_we      = 1'b0;
    bm_waddr   = '0;
    bm_wdata   = '0;
    bm_raddr   = rel_widx[bia_pkg::WADDR-1:0];
    sum_we     = 1'b0;
    sum_waddr  = grp;
    sum_wdata  = '0;
    sum_raddr  = (cmd.command == bia_pkg::CMD_RELEASE) ? rel_grp
                                                      : ffz_idx[bia_pkg::GRP_W-1:0];
    top_set    = 1'b0;
    top_clr    = 1'b0;
    gid_load   = 1'b0;
    gid_next   = '0;
    case (state)
      bia_pkg::S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_cnt[bia_pkg::WADDR-1:0];
        bm_wdata = (clr_cnt == '0) ? bia_pkg::RESERVED_MASK : '0;
        sum_we   = (32'(clr_cnt) < 32'(bia_pkg::GROUPS));
        sum_waddr = clr_cnt[bia_pkg::GRP_W-1:0];
        sum_wdata = bia_pkg::sum_init(clr_cnt[bia_pkg::GRP_W-1:0]);
        if (32'(clr_cnt) == 32'(bia_pkg::WORDS - 1)) state_next = bia_pkg::S_IDLE;
      end
      bia_pkg::S_IDLE: begin
        if (acc) begin
          if (cmd.command == bia_pkg::CMD_ALLOC) begin
            if (ffz_full) begin
              gid_load = 1'b1;  // nothing free: answer 0
            end else begin
              state_next = bia_pkg::S_SUM;
            end
          end else if (rel_ok) begin
            state_next = bia_pkg::S_REL;
          end
        end
      end
      bia_pkg::S_SUM: begin
        bm_raddr   = srch_widx[bia_pkg::WADDR-1:0];
        sum_raddr  = grp;  // keep the group's summary for the update
        state_next = bia_pkg::S_WORD;
      end
      bia_pkg::S_WORD: begin
        bm_we     = 1'b1;
        bm_waddr  = cur_widx[bia_pkg::WADDR-1:0];
        bm_wdata  = bm_set;
        sum_we    = &bm_set;
        sum_wdata = sum_set;
        top_set   = (&bm_set) && (&sum_set);
        gid_load  = 1'b1;
        gid_next  = gid_wide[bia_pkg::ID_W-1:0];
        state_next = bia_pkg::S_IDLE;
      end
      bia_pkg::S_REL: begin
        bm_we     = 1'b1;
        bm_waddr  = cur_widx[bia_pkg::WADDR-1:0];
        bm_wdata  = bm_q & ~(WW'(1) << rbit);
        sum_we    = 1'b1;
        sum_wdata = sum_q & ~(WW'(1) << wsel);
        top_clr   = 1'b1;
        state_next = bia_pkg::S_IDLE;
      end
      default: state_next = bia_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_q <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bia_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      top       <= bia_pkg::TOP_RESET;
      res_valid <= 1'b0;
    end else begin
      if (state == bia_pkg::S_CLEAR) clr_cnt <= clr_cnt + (bia_pkg::WADDR + 1)'(1);
      if (top_set) begin
        top[grp] <= 1'b1;
      end else if (top_clr) begin
        top[grp] <= 1'b0;
      end
      if (gid_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      grp  <= (cmd.command == bia_pkg::CMD_RELEASE) ? rel_grp
                                                    : ffz_idx[bia_pkg::GRP_W-1:0];
      wsel <= rel_widx[bia_pkg::BIT_W-1:0];
      rbit <= id_ext[bia_pkg::BIT_W-1:0];
    end else if (state == bia_pkg::S_SUM) begin
      wsel <= ffz_idx;
    end
    if (gid_load) gid <= gid_next;
  end

  // a group with room must lead to a word with room
  `BIA_ASSERT_IMPL(a_word_has_room, clk, rst, state == bia_pkg::S_WORD, !ffz_full, "summary says free but bitmap word is full")
  // an allocate with a free group yields a result after S_SUM and S_WORD
  `BIA_ASSERT_IMPL(a_alloc_latency, clk, rst, acc && (cmd.command == bia_pkg::CMD_ALLOC) && !ffz_full, ##3 res_valid, "allocate result missing")
  // identifier 1 is reserved and never handed out
  `BIA_ASSERT(a_no_reserved, clk, rst, !(res_valid && (gid == bia_pkg::ID_W'(1))), "reserved identifier granted")
endmodule
`default_nettype wire

// ----- rtl/bia_ffz.sv -----
// Lowest-clear-bit encoder over one 32-bit word.
`default_nettype none
module bia_ffz (
  input  logic [bia_pkg::WORD_W-1:0] word,
  output logic [bia_pkg::BIT_W-1:0]  idx,
  output logic                       full
);
  logic [bia_pkg::WORD_W-1:0] onehot;

  always_comb begin
    onehot = ~word & (word + bia_pkg::WORD_W'(1));
    idx    = '0;
    for (int i = 0; i < bia_pkg::WORD_W; i++) begin
      if (onehot[i]) idx = idx | bia_pkg::BIT_W'(i);
    end
    full = &word;
  end
endmodule
`default_nettype wire

// ----- verif/bitmap_id_allocator_tb.sv -----
// Self-checking testbench of the bitmap identifier allocator.
`timescale 1ns / 100ps
module bitmap_id_allocator_tb;

  logic clk;
  logic rst;

  bia_cmd_if cmd_if ();
  bia_res_if res_if ();

  bitmap_id_allocator dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  // Shadow of the usage bitmap: one bit per identifier, set = in use.
  logic [bia_pkg::WORD_W-1:0] in_use_map [bia_pkg::WORDS];
  // Grants predicted at command acceptance, oldest first.
  logic [bia_pkg::ID_W-1:0]   pending_grants [$];
  int                top_grant;   // highest identifier handed out so far
  int                fail_count;
  bit                no_gaps;     // suppresses idling on both channels

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop, well past the slowest legal run (clearing pass plus all
  // test traffic with both sides idling).
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // Random idle decision, shared by the command and result sides.
  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 30);
  endfunction

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // First-free scan: skip full words, take the lowest clear bit of the
  // first word with room. A full map answers 0 and stays unchanged.
  function automatic logic [bia_pkg::ID_W-1:0] grant_lowest_free();
    for (int w = 0; w < bia_pkg::WORDS; w++) begin
      if (in_use_map[w] != bia_pkg::FULL_WORD) begin
        for (int b = 0; b < bia_pkg::WORD_W; b++) begin
          if (!in_use_map[w][b]) begin
            in_use_map[w][b] = 1'b1;
            if (w * bia_pkg::WORD_W + b > top_grant) top_grant = w * bia_pkg::WORD_W + b;
            return bia_pkg::ID_W'(w * bia_pkg::WORD_W + b);
          end
        end
      end
    end
    return '0;
  endfunction

  // Reserved ids and ids past the bitmap are dropped; freeing a free id is
  // a no-op.
  function automatic void free_identifier(input logic [bia_pkg::ID_W-1:0] id);
    if (int'(id) < bia_pkg::RESERVED_IDS || int'(id) >= bia_pkg::ID_LIMIT) return;
    in_use_map[id >> bia_pkg::BIT_W][id[bia_pkg::BIT_W-1:0]] = 1'b0;
  endfunction

  // Mostly an identifier that is currently held, so releases do real work.
  function automatic logic [bia_pkg::ID_W-1:0] pick_held_id();
    logic [bia_pkg::ID_W-1:0] id;
    id = bia_pkg::ID_W'(bia_pkg::RESERVED_IDS);
    for (int t = 0; t < 8; t++) begin
      id = bia_pkg::ID_W'($urandom_range(top_grant, bia_pkg::RESERVED_IDS));
      if (in_use_map[id >> bia_pkg::BIT_W][id[bia_pkg::BIT_W-1:0]]) return id;
    end
    return id;
  endfunction

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------

  // Drives a command transaction; called just after the clock rises. valid is
  // left high on return so back-to-back commands need no second drive.
  task automatic send_cmd(input logic op, input logic [bia_pkg::ID_W-1:0] id);
    while (take_gap()) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= op;
    cmd_if.release_id <= id;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    // accepted at this edge: advance the shadow state in acceptance order
    if (op == bia_pkg::CMD_ALLOC) pending_grants.push_back(grant_lowest_free());
    else free_identifier(id);
  endtask

  // Allocate with a random, ignored release_id field.
  task automatic send_alloc();
    send_cmd(bia_pkg::CMD_ALLOC, bia_pkg::ID_W'($urandom_range(2**bia_pkg::ID_W - 1, 0)));
  endtask

  // ---------------------------------------------------------------------
  // Result side: random backpressure, in-order compare
  // ---------------------------------------------------------------------
  initial begin : grant_checker
    logic [bia_pkg::ID_W-1:0] want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        if (pending_grants.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("grant %0d with no allocate outstanding at %0t",
                     res_if.granted_id, $time);
        end else begin
          want = pending_grants.pop_front();
          if (res_if.granted_id !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("granted_id mismatch at %0t: expected %0d, actual %0d",
                       $time, want, res_if.granted_id);
          end
        end
      end
      res_if.ready <= !take_gap();
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Fresh map: grants start at 2 and always take the lowest free id.
  task automatic test_first_grants();
    send_cmd(bia_pkg::CMD_ALLOC, '1);      // payload field ignored on allocate
    send_cmd(bia_pkg::CMD_ALLOC, '0);
    send_alloc();                          // 2, 3, 4
    send_cmd(bia_pkg::CMD_RELEASE, 15'd3);
    send_alloc();                          // 3 again
    send_cmd(bia_pkg::CMD_RELEASE, 15'd2);
    send_cmd(bia_pkg::CMD_RELEASE, 15'd4);
    send_alloc();                          // 2 before 4
    send_alloc();                          // 4
  endtask

  // Releases that must leave the map alone, around one real release of 5.
  task automatic test_ignored_releases();
    send_cmd(bia_pkg::CMD_RELEASE, 15'd0);     // reserved
    send_cmd(bia_pkg::CMD_RELEASE, 15'd1);     // reserved
    send_alloc();                              // 5, not 0 or 1
    send_cmd(bia_pkg::CMD_RELEASE, 15'd100);   // never allocated
    send_cmd(bia_pkg::CMD_RELEASE, 15'h7fff);  // top id, free
    send_cmd(bia_pkg::CMD_RELEASE, 15'd5);
    send_cmd(bia_pkg::CMD_RELEASE, 15'd5);     // double release
    send_alloc();                              // 5
  endtask

  // Mixed traffic: mostly allocates and releases of held ids, so the map
  // grows over several words and full words get skipped; the rest is
  // noise on reserved, free and arbitrary ids. A middle stretch runs with
  // no idling on either side.
  task automatic test_random_traffic();
    int roll;
    for (int n = 0; n < 640; n++) begin
      no_gaps = (n >= 260 && n < 380);
      roll = $urandom_range(99);
      if (roll < 50) send_alloc();
      else if (roll < 85) send_cmd(bia_pkg::CMD_RELEASE, pick_held_id());
      else if (roll < 90)
        send_cmd(bia_pkg::CMD_RELEASE,
                 bia_pkg::ID_W'($urandom_range(bia_pkg::RESERVED_IDS - 1, 0)));
      else send_cmd(bia_pkg::CMD_RELEASE,
                    bia_pkg::ID_W'($urandom_range(2**bia_pkg::ID_W - 1, 0)));
    end
    no_gaps = 1'b0;
  endtask

  // Pack whole words with a burst of allocates, then punch holes and see
  // them refilled lowest first.
  task automatic test_refill();
    repeat (64) send_alloc();
    send_cmd(bia_pkg::CMD_RELEASE, 15'd0);
    send_cmd(bia_pkg::CMD_RELEASE, 15'd1);
    send_alloc();                          // reserved ids stay out
    repeat (4) send_cmd(bia_pkg::CMD_RELEASE, pick_held_id());
    repeat (5) send_alloc();               // holes in order, then fresh ids
    for (int n = 0; n < 20; n++) begin
      send_cmd(bia_pkg::CMD_RELEASE, pick_held_id());
      send_alloc();
    end
    send_alloc();
  endtask

  // Wait for outstanding grants (bounded), then idle on to catch stray
  // transactions; anything still expected is a failure.
  task automatic drain_and_settle();
    cmd_if.valid <= 1'b0;
    for (int c = 0; c < 4000 && pending_grants.size() != 0; c++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_grants.size() != 0) begin
      fail_count += pending_grants.size();
      if (fail_count <= 10)
        $display("%0d grants never arrived, next expected %0d",
                 pending_grants.size(), pending_grants[0]);
    end
  endtask

  initial begin
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= bia_pkg::CMD_ALLOC;
    cmd_if.release_id <= '0;
    rst               <= 1'b1;
    no_gaps    = 1'b0;
    fail_count = 0;
    top_grant  = bia_pkg::RESERVED_IDS;
    foreach (in_use_map[w]) in_use_map[w] = '0;
    in_use_map[0] = bia_pkg::RESERVED_MASK;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset: send_cmd simply waits on cmd.ready

    test_first_grants();
    test_ignored_releases();
    test_random_traffic();
    test_refill();
    drain_and_settle();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
